FILE: rtl/rhlh_pkg.sv
// Shared types and constants for the Robin Hood label hash table.
package rhlh_pkg;

   localparam int TABLE_SIZE_DEF    = 64;
   localparam int MAX_KEY_CHARS_DEF = 8;
   localparam int VALUE_BITS_DEF    = 32;

   localparam int KEY_PORT_BITS   = 64;
   localparam int LEN_BITS        = 4;
   localparam int PORT_VALUE_BITS = 32;
   localparam int LIMIT_BITS      = 7;
   localparam int PROBE_BITS      = 6;
   localparam int PROBE_OUT_MAX   = 63;
   localparam int HASH_START      = 5381;
   localparam logic [LIMIT_BITS-1:0] FILL_RESET = 7'd57;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   typedef enum logic [1:0] {
      RES_INSERTED  = 2'd0,
      RES_FOUND     = 2'd1,
      RES_NOT_FOUND = 2'd2,
      RES_FULL      = 2'd3
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_PROBE,
      ST_EVAL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic       load;
      logic       init;
      logic       count_inc;
      logic       place;
      logic       mem_rd;
      logic       swap_step;
      logic       next_slot;
      logic       set_result;
      result_type result;
      logic       take_value;
      logic       probe_from_dist;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic is_lookup;
      logic full;
      logic lk_stop;
      logic slot_empty;
      logic slot_match;
      logic rsp_free;
   } stat_type;

endpackage

FILE: rtl/robin_hood_label_hash_table_top.sv
// Top level of the Robin Hood label hash table.
//  channel | handshake             | payload
//  req     | req_valid/req_ready   | type, key_chars, key_length, entry_value
//  rsp     | rsp_valid/rsp_ready   | status, result_value, probe_distance
//  csr     | csr_we                | fill_limit (csr_wdata)
// An insert or a miss goes IDLE, HASH, then PROBE (table read) and EVAL (compare or
// swap) for each occupied slot visited, then FINISH; a hit ends from EVAL instead of
// PROBE; a refused insert goes from HASH to FINISH. The slot table is single ported.
// Reset is synchronous; it empties the table with no sweep (per-slot valid bits).
// A new request is taken while a result waits; a finished one holds until rsp_ready.
module robin_hood_label_hash_table_top #(
   parameter int TABLE_SIZE    = rhlh_pkg::TABLE_SIZE_DEF,
   parameter int MAX_KEY_CHARS = rhlh_pkg::MAX_KEY_CHARS_DEF,
   parameter int VALUE_BITS    = rhlh_pkg::VALUE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_type,
   input  logic [rhlh_pkg::KEY_PORT_BITS-1:0]   req_key_chars,
   input  logic [rhlh_pkg::LEN_BITS-1:0]        req_key_length,
   input  logic [rhlh_pkg::PORT_VALUE_BITS-1:0] req_entry_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_status,
   output logic [rhlh_pkg::PORT_VALUE_BITS-1:0] rsp_result_value,
   output logic [rhlh_pkg::PROBE_BITS-1:0]      rsp_probe_distance,
   input  logic                                 csr_we,
   input  logic [rhlh_pkg::LIMIT_BITS-1:0]      csr_wdata
);

   rhlh_pkg::cmd_type  cmd;
   rhlh_pkg::stat_type stat;

   rhlh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rhlh_dp #(
      .TABLE_SIZE    (TABLE_SIZE),
      .MAX_KEY_CHARS (MAX_KEY_CHARS),
      .VALUE_BITS    (VALUE_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_type           (req_type),
      .req_key_chars      (req_key_chars),
      .req_key_length     (req_key_length),
      .req_entry_value    (req_entry_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_result_value   (rsp_result_value),
      .rsp_probe_distance (rsp_probe_distance),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .cmd                (cmd),
      .stat               (stat)
   );

endmodule

FILE: rtl/rhlh_ram.sv
// Generic single-port RAM with registered read.
module rhlh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

endmodule

FILE: rtl/rhlh_ctrl.sv
// Request sequencer: hash, probe walk and response hand-off.
module rhlh_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rhlh_pkg::stat_type stat,
   output rhlh_pkg::cmd_type  cmd
);

   rhlh_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rhlh_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rhlh_pkg::ST_IDLE: begin
            if (req_valid) state_in = rhlh_pkg::ST_HASH;
         end
         rhlh_pkg::ST_HASH: begin
            if (!stat.is_lookup && stat.full) state_in = rhlh_pkg::ST_FINISH;
            else state_in = rhlh_pkg::ST_PROBE;
         end
         rhlh_pkg::ST_PROBE: begin
            if (stat.is_lookup ? stat.lk_stop : stat.slot_empty) begin
               state_in = rhlh_pkg::ST_FINISH;
            end else begin
               state_in = rhlh_pkg::ST_EVAL;
            end
         end
         rhlh_pkg::ST_EVAL: begin
            if (stat.is_lookup && stat.slot_match) state_in = rhlh_pkg::ST_FINISH;
            else state_in = rhlh_pkg::ST_PROBE;
         end
         rhlh_pkg::ST_FINISH: begin
            if (stat.rsp_free) state_in = rhlh_pkg::ST_IDLE;
         end
         default: state_in = rhlh_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.result = rhlh_pkg::RES_INSERTED;
      req_ready = 1'b0;
      unique case (state_ff)
         rhlh_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         rhlh_pkg::ST_HASH: begin
            cmd.init = 1'b1;
            if (!stat.is_lookup) begin
               if (stat.full) begin
                  cmd.set_result = 1'b1;
                  cmd.result = rhlh_pkg::RES_FULL;
               end else begin
                  cmd.count_inc = 1'b1;
               end
            end
         end
         rhlh_pkg::ST_PROBE: begin
            if (stat.is_lookup) begin
               if (stat.lk_stop) begin
                  cmd.set_result = 1'b1;
                  cmd.result = rhlh_pkg::RES_NOT_FOUND;
                  cmd.probe_from_dist = 1'b1;
               end else begin
                  cmd.mem_rd = 1'b1;
               end
            end else if (stat.slot_empty) begin
               cmd.place = 1'b1;
               cmd.set_result = 1'b1;
               cmd.result = rhlh_pkg::RES_INSERTED;
            end else begin
               cmd.mem_rd = 1'b1;
            end
         end
         rhlh_pkg::ST_EVAL: begin
            if (stat.is_lookup) begin
               if (stat.slot_match) begin
                  cmd.set_result = 1'b1;
                  cmd.result = rhlh_pkg::RES_FOUND;
                  cmd.take_value = 1'b1;
                  cmd.probe_from_dist = 1'b1;
               end else begin
                  cmd.next_slot = 1'b1;
               end
            end else begin
               cmd.swap_step = 1'b1;
            end
         end
         rhlh_pkg::ST_FINISH: begin
            cmd.rsp_load = stat.rsp_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

FILE: rtl/rhlh_dp.sv
// Datapath: request registers, hash, slot table, carried entry and response register.
module rhlh_dp #(
   parameter int TABLE_SIZE    = rhlh_pkg::TABLE_SIZE_DEF,
   parameter int MAX_KEY_CHARS = rhlh_pkg::MAX_KEY_CHARS_DEF,
   parameter int VALUE_BITS    = rhlh_pkg::VALUE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_type,
   input  logic [rhlh_pkg::KEY_PORT_BITS-1:0]    req_key_chars,
   input  logic [rhlh_pkg::LEN_BITS-1:0]         req_key_length,
   input  logic [rhlh_pkg::PORT_VALUE_BITS-1:0]  req_entry_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_status,
   output logic [rhlh_pkg::PORT_VALUE_BITS-1:0]  rsp_result_value,
   output logic [rhlh_pkg::PROBE_BITS-1:0]       rsp_probe_distance,
   input  logic                                  csr_we,
   input  logic [rhlh_pkg::LIMIT_BITS-1:0]       csr_wdata,
   input  rhlh_pkg::cmd_type                     cmd,
   output rhlh_pkg::stat_type                    stat
);

   localparam int SLOT_BITS = $clog2(TABLE_SIZE);
   localparam int DIST_BITS = SLOT_BITS + 1;
   localparam int KEY_W     = 8 * MAX_KEY_CHARS;
   localparam int LB        = rhlh_pkg::LEN_BITS;
   localparam int ENT_W     = KEY_W + LB + VALUE_BITS + SLOT_BITS;
   localparam int CMP_W     = (DIST_BITS > rhlh_pkg::LIMIT_BITS) ? DIST_BITS
                                                                 : rhlh_pkg::LIMIT_BITS;
   localparam int PW        = (DIST_BITS > rhlh_pkg::PROBE_BITS) ? DIST_BITS
                                                                 : rhlh_pkg::PROBE_BITS;
   localparam int HOME_LO   = 0;
   localparam int VAL_LO    = SLOT_BITS;
   localparam int LEN_LO    = SLOT_BITS + VALUE_BITS;
   localparam int KEY_LO    = SLOT_BITS + VALUE_BITS + LB;

   logic                        type_ff;
   logic [KEY_W-1:0]            key_ff;
   logic [LB-1:0]               len_ff;
   logic [SLOT_BITS-1:0]        pos_ff;
   logic [DIST_BITS-1:0]        dist_ff;
   logic [KEY_W-1:0]            c_key_ff;
   logic [LB-1:0]               c_len_ff;
   logic [VALUE_BITS-1:0]       c_val_ff;
   logic [SLOT_BITS-1:0]        c_home_ff;
   logic                        placed_ff;
   logic [DIST_BITS-1:0]        probe_ff;
   logic [DIST_BITS-1:0]        count_ff;
   logic [SLOT_BITS-1:0]        longest_ff;
   logic [rhlh_pkg::LIMIT_BITS-1:0] limit_ff;
   logic [TABLE_SIZE-1:0]       valid_ff;
   rhlh_pkg::result_type        code_ff;
   logic [VALUE_BITS-1:0]       fval_ff;
   logic                        rsp_valid_ff;
   logic [1:0]                  rsp_status_ff;
   logic [rhlh_pkg::PORT_VALUE_BITS-1:0] rsp_value_ff;
   logic [rhlh_pkg::PROBE_BITS-1:0]      rsp_probe_ff;

   logic [LB-1:0]          len_sat;
   logic [KEY_W-1:0]       key_masked;
   logic [SLOT_BITS-1:0]   home;
   logic [ENT_W-1:0]       ram_rdata;
   logic [ENT_W-1:0]       ram_wdata;
   logic                   ram_we;
   logic [KEY_W-1:0]       s_key;
   logic [LB-1:0]          s_len;
   logic [VALUE_BITS-1:0]  s_val;
   logic [SLOT_BITS-1:0]   s_home;
   logic [SLOT_BITS-1:0]   rdist;
   logic                   do_swap;
   logic [DIST_BITS-1:0]   step_dist;
   logic [PW-1:0]          probe_ext;

   always_comb begin
      len_sat = (req_key_length > LB'(MAX_KEY_CHARS)) ? LB'(MAX_KEY_CHARS) : req_key_length;
      for (int i = 0; i < MAX_KEY_CHARS; i++) begin
         key_masked[i*8 +: 8] = (LB'(i) < len_sat) ? req_key_chars[i*8 +: 8] : 8'd0;
      end
   end

   always_comb begin
      home = SLOT_BITS'(rhlh_pkg::HASH_START);
      for (int i = 0; i < MAX_KEY_CHARS; i++) begin
         if (LB'(i) < len_ff) begin
            home = (home << 5) + home + SLOT_BITS'(key_ff[i*8 +: 8]);
         end
      end
   end

   assign s_key  = ram_rdata[KEY_LO +: KEY_W];
   assign s_len  = ram_rdata[LEN_LO +: LB];
   assign s_val  = ram_rdata[VAL_LO +: VALUE_BITS];
   assign s_home = ram_rdata[HOME_LO +: SLOT_BITS];
   assign rdist  = pos_ff - s_home;
   assign do_swap = DIST_BITS'(rdist) < dist_ff;
   assign step_dist = do_swap ? DIST_BITS'(rdist) : dist_ff;
   assign ram_we = cmd.place | (cmd.swap_step & do_swap);
   assign ram_wdata = {c_key_ff, c_len_ff, c_val_ff, c_home_ff};

   rhlh_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_SIZE)) u_ram (
      .clock    (clock),
      .we       (ram_we),
      .addr     (pos_ff),
      .wdata    (ram_wdata),
      .rdata_ff (ram_rdata)
   );

   assign stat.is_lookup  = (type_ff == rhlh_pkg::REQ_LOOKUP);
   assign stat.full       = (CMP_W'(count_ff) >= CMP_W'(limit_ff))
                            || (count_ff >= DIST_BITS'(TABLE_SIZE));
   assign stat.slot_empty = !valid_ff[pos_ff];
   assign stat.lk_stop    = (dist_ff >= DIST_BITS'(TABLE_SIZE))
                            || (dist_ff > DIST_BITS'(longest_ff)) || !valid_ff[pos_ff];
   assign stat.slot_match = (s_len == len_ff) && (s_key == key_ff);
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign probe_ext = PW'(probe_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff  <= req_type;
         key_ff   <= key_masked;
         len_ff   <= len_sat;
         c_val_ff <= VALUE_BITS'(req_entry_value);
      end
      if (cmd.init) begin
         pos_ff    <= home;
         dist_ff   <= '0;
         c_key_ff  <= key_ff;
         c_len_ff  <= len_ff;
         c_home_ff <= home;
         placed_ff <= 1'b0;
         probe_ff  <= '0;
      end
      if (cmd.place && !placed_ff) begin
         probe_ff <= dist_ff;
      end
      if (cmd.swap_step) begin
         if (do_swap) begin
            c_key_ff  <= s_key;
            c_len_ff  <= s_len;
            c_val_ff  <= s_val;
            c_home_ff <= s_home;
            if (!placed_ff) begin
               probe_ff  <= dist_ff;
               placed_ff <= 1'b1;
            end
         end
         pos_ff  <= pos_ff + 1'b1;
         dist_ff <= step_dist + 1'b1;
      end
      if (cmd.next_slot) begin
         pos_ff  <= pos_ff + 1'b1;
         dist_ff <= dist_ff + 1'b1;
      end
      if (cmd.set_result) begin
         code_ff <= cmd.result;
         fval_ff <= cmd.take_value ? s_val : '0;
         if (cmd.probe_from_dist) probe_ff <= dist_ff;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= code_ff;
         rsp_value_ff  <= rhlh_pkg::PORT_VALUE_BITS'(fval_ff);
         rsp_probe_ff  <= (probe_ext > PW'(rhlh_pkg::PROBE_OUT_MAX))
                          ? rhlh_pkg::PROBE_BITS'(rhlh_pkg::PROBE_OUT_MAX)
                          : probe_ext[rhlh_pkg::PROBE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         longest_ff   <= '0;
         limit_ff     <= rhlh_pkg::FILL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) limit_ff <= csr_wdata;
         if (cmd.count_inc) count_ff <= count_ff + 1'b1;
         if (cmd.place) valid_ff[pos_ff] <= 1'b1;
         if ((cmd.place || (cmd.swap_step && do_swap))
             && (dist_ff > DIST_BITS'(longest_ff))) begin
            longest_ff <= dist_ff[SLOT_BITS-1:0];
         end
         if (cmd.rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_value   = rsp_value_ff;
   assign rsp_probe_distance = rsp_probe_ff;

endmodule
